### hw/rtl/dsrm_pkg.sv
package dsrm_pkg;

   // Pattern metacharacters
   localparam logic [7:0] CH_ANY  = 8'h2E;
   localparam logic [7:0] CH_STAR = 8'h2A;

   // Pattern storage: four 64-bit registers, eight characters each
   localparam int NUM_CHAR_REGS   = 4;
   localparam int CHARS_PER_REG   = 8;
   localparam int NUM_CHARS       = NUM_CHAR_REGS * CHARS_PER_REG;
   localparam int CHAR_BITS_W     = NUM_CHARS * 8;
   localparam int LEN_W           = 6;
   localparam int MAX_PATTERN_DEF = 32;

   // Configuration port
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATTERN_LENGTH  = 3'd0,
      REG_PATTERN_CHARS_0 = 3'd1,
      REG_PATTERN_CHARS_1 = 3'd2,
      REG_PATTERN_CHARS_2 = 3'd3,
      REG_PATTERN_CHARS_3 = 3'd4
   } reg_index_type;

   // Pattern configuration handed from the register file to the row logic
   typedef struct packed {
      logic [LEN_W-1:0]       pattern_length;
      logic [CHAR_BITS_W-1:0] pattern_chars;
   } pattern_cfg_type;

   // One text request as held in the input register
   typedef struct packed {
      logic [7:0] text_char;
      logic       no_char;
      logic       last;
   } req_item_type;

endpackage

### hw/rtl/dsrm_csr.sv
module dsrm_csr
   import dsrm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output pattern_cfg_type       cfg
);

   logic [LEN_W-1:0]      length_ff;
   logic [LEN_W-1:0]      length_in;
   logic [CSR_DATA_W-1:0] chars_ff [NUM_CHAR_REGS];
   logic [CSR_DATA_W-1:0] chars_in [NUM_CHAR_REGS];
   reg_index_type         reg_idx;
   logic                  wr_en;

   assign pready  = 1'b1;
   assign reg_idx = reg_index_type'(paddr[CSR_ADDR_W-1:3]);
   assign wr_en   = psel & penable & pwrite;

   // Next register values
   always_comb begin
      length_in = length_ff;
      for (int k = 0; k < NUM_CHAR_REGS; k++) begin
         chars_in[k] = chars_ff[k];
      end
      if (wr_en) begin
         case (reg_idx)
            REG_PATTERN_LENGTH:  length_in   = pwdata[LEN_W-1:0];
            REG_PATTERN_CHARS_0: chars_in[0] = pwdata;
            REG_PATTERN_CHARS_1: chars_in[1] = pwdata;
            REG_PATTERN_CHARS_2: chars_in[2] = pwdata;
            REG_PATTERN_CHARS_3: chars_in[3] = pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         for (int k = 0; k < NUM_CHAR_REGS; k++) begin
            chars_ff[k] <= '0;
         end
      end else begin
         length_ff <= length_in;
         for (int k = 0; k < NUM_CHAR_REGS; k++) begin
            chars_ff[k] <= chars_in[k];
         end
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         REG_PATTERN_LENGTH:  prdata = CSR_DATA_W'(length_ff);
         REG_PATTERN_CHARS_0: prdata = chars_ff[0];
         REG_PATTERN_CHARS_1: prdata = chars_ff[1];
         REG_PATTERN_CHARS_2: prdata = chars_ff[2];
         REG_PATTERN_CHARS_3: prdata = chars_ff[3];
         default:             prdata = '0;
      endcase
   end

   // Pattern view for the row logic, lowest character in the low byte
   always_comb begin
      cfg.pattern_length = length_ff;
      for (int k = 0; k < NUM_CHAR_REGS; k++) begin
         cfg.pattern_chars[k*CSR_DATA_W +: CSR_DATA_W] = chars_ff[k];
      end
   end

endmodule

### hw/rtl/dsrm_row_eval.sv
module dsrm_row_eval
   import dsrm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  pattern_cfg_type        cfg,
   input  req_item_type           item,
   input  logic                   at_start,
   input  logic [MAX_PATTERN:0]   match_row,
   output logic [MAX_PATTERN:0]   next_row,
   output logic                   matched
);

   localparam int ROW_W   = MAX_PATTERN + 1;
   localparam int IDX_W   = (ROW_W > 1) ? $clog2(ROW_W) : 1;
   localparam int PBYTES  = (MAX_PATTERN > NUM_CHARS) ? MAX_PATTERN : NUM_CHARS;
   localparam int PAT_W   = PBYTES * 8;

   logic [PAT_W-1:0] pat_ext;
   logic [LEN_W-1:0] used_len;
   logic [ROW_W-1:0] empty_row;
   logic [ROW_W-1:0] prev_row;
   logic [ROW_W-1:0] char_row;

   // Positions past the registers read as byte zero
   assign pat_ext = PAT_W'(cfg.pattern_chars);

   // Length saturates to MAX_PATTERN, the last cell of the row
   assign used_len = (cfg.pattern_length > LEN_W'(MAX_PATTERN)) ?
                     LEN_W'(MAX_PATTERN) : cfg.pattern_length;

   // One row step. Star cells chain through the row being built, much like
   // a ripple carry: a star cell takes its two left neighbours.
   function automatic logic [ROW_W-1:0] step_row(
      input logic [ROW_W-1:0] prev,
      input logic [7:0]       ch,
      input logic             has_char,
      input logic [LEN_W-1:0] n,
      input logic [PAT_W-1:0] pat
   );
      logic [ROW_W-1:0] row;
      logic [7:0]       pc;
      logic [7:0]       pb;
      logic             b;
      row    = '0;
      row[0] = ~has_char;
      for (int j = 1; j < ROW_W; j++) begin
         pc = pat[8*(j-1) +: 8];
         pb = (j > 1) ? pat[8*((j > 1) ? j-2 : 0) +: 8] : 8'h00;
         b  = 1'b0;
         if (pc == CH_ANY) begin
            b = has_char & prev[j-1];
         end else if (pc == CH_STAR) begin
            if (j > 1) begin
               b = row[j-1] | row[(j > 1) ? j-2 : 0] |
                   (has_char & ((pb == ch) | (pb == CH_ANY)) & prev[j]);
            end
         end else begin
            b = has_char & (ch == pc) & prev[j-1];
         end
         if (j <= int'(n)) begin
            row[j] = b;
         end
      end
      return row;
   endfunction

   // Empty-text row, then the row after this character
   always_comb begin
      empty_row = step_row('0, 8'h00, 1'b0, used_len, pat_ext);
      prev_row  = at_start ? empty_row : match_row;
      char_row  = step_row(prev_row, item.text_char, 1'b1, used_len, pat_ext);
      next_row  = item.no_char ? prev_row : char_row;
      matched   = next_row[used_len[IDX_W-1:0]];
   end

endmodule

### hw/rtl/dot_star_regex_matcher_top.sv
// Path: an accepted request is held in the input register, then the row
// logic writes its result into the result register.
// Throughput: one request per cycle, except that a last request waits while
// the result slot is full; the next row depends only on the row register.
// Reset: synchronous, clears the pattern registers, the row and the pipeline.
module dot_star_regex_matcher_top
   import dsrm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Text requests
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_text_char,
   input  logic                  req_no_char,
   input  logic                  req_last,
   // Match results
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_matched,
   // Configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   pattern_cfg_type      cfg;
   req_item_type         item_ff;
   req_item_type         item_in;
   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [MAX_PATTERN:0] row_ff;
   logic [MAX_PATTERN:0] row_in;
   logic                 at_start_ff;
   logic                 at_start_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 matched_ff;
   logic                 matched_in;
   logic [MAX_PATTERN:0] next_row;
   logic                 matched;
   logic                 advance;
   logic                 req_take;

   dsrm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dsrm_row_eval #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_row_eval (
      .cfg       (cfg),
      .item      (item_ff),
      .at_start  (at_start_ff),
      .match_row (row_ff),
      .next_row  (next_row),
      .matched   (matched)
   );

   // A held request moves on unless it is last and the result slot is full
   assign advance   = in_valid_ff & (~item_ff.last | ~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign req_take  = req_valid & req_ready;

   // Input register
   always_comb begin
      item_in = item_ff;
      if (req_take) begin
         item_in.text_char = req_text_char;
         item_in.no_char   = req_no_char;
         item_in.last      = req_last;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Row state and result register
   always_comb begin
      row_in       = row_ff;
      at_start_in  = at_start_ff;
      matched_in   = matched_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (advance) begin
         row_in      = next_row;
         at_start_in = item_ff.last;
         if (item_ff.last) begin
            matched_in   = matched;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         row_ff       <= '0;
         at_start_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         row_ff       <= row_in;
         at_start_ff  <= at_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      matched_ff <= matched_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = matched_ff;

endmodule
